// ===== src/lstp_pkg.sv =====
// Types, register indexes and constant tables shared by the scan-to-point block.
// No dependencies.
package lstp_pkg;

   localparam int CordicMaxStages = 24;
   localparam logic signed [17:0] CordicGainQ14 = 18'sd9949;
   localparam int CsrIndexWidth = 4;
   localparam int CsrDataWidth = 64;

   localparam logic [CsrIndexWidth-1:0] CSR_START_ANGLE    = 4'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_ANGLE_STEP     = 4'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MIN_RANGE      = 4'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_MAX_RANGE      = 4'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_ROTATION_XY    = 4'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_ROTATION_Z_OFS = 4'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_OFFSET_XY      = 4'd6;
   localparam logic [CsrIndexWidth-1:0] CSR_FOOTPRINT_HALF = 4'd7;

   typedef struct packed {
      logic signed [17:0] x;
      logic signed [17:0] y;
      logic signed [31:0] z;
      logic [1:0]         quad;
      logic [15:0]        range_mm;
      logic [11:0]        beam_index;
   } lstp_cell_type;

   typedef struct packed {
      logic [63:0] rotation_xy;
      logic [63:0] rotation_z_offset;
      logic [63:0] offset_xy;
      logic [31:0] footprint_half;
   } lstp_csr_type;

   function automatic logic signed [31:0] atan_turns(input int stage);
      logic signed [31:0] t;
      case (stage)
         0: t = 32'sd536870912;
         1: t = 32'sd316933406;
         2: t = 32'sd167458907;
         3: t = 32'sd85004756;
         4: t = 32'sd42667331;
         5: t = 32'sd21354465;
         6: t = 32'sd10679838;
         7: t = 32'sd5340245;
         8: t = 32'sd2670163;
         9: t = 32'sd1335087;
         10: t = 32'sd667544;
         11: t = 32'sd333772;
         12: t = 32'sd166886;
         13: t = 32'sd83443;
         14: t = 32'sd41722;
         15: t = 32'sd20861;
         16: t = 32'sd10430;
         17: t = 32'sd5215;
         18: t = 32'sd2608;
         19: t = 32'sd1304;
         20: t = 32'sd652;
         21: t = 32'sd326;
         22: t = 32'sd163;
         23: t = 32'sd81;
         default: t = 32'sd0;
      endcase
      return t;
   endfunction

   function automatic logic signed [19:0] sat20(input logic signed [35:0] v);
      logic signed [19:0] r;
      if (v > 36'sd524287) begin
         r = 20'sd524287;
      end else if (v < -36'sd524288) begin
         r = -20'sd524288;
      end else begin
         r = v[19:0];
      end
      return r;
   endfunction

endpackage

// ===== src/lstp_if.sv =====
// Handshake channels for range samples in and body-frame points out.
// No dependencies.
interface lstp_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] range_mm;
   logic        range_finite;
   logic [11:0] beam_index;
   modport source (output valid, range_mm, range_finite, beam_index, input ready);
   modport sink (input valid, range_mm, range_finite, beam_index, output ready);
endinterface

interface lstp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [19:0] point_x;
   logic signed [19:0] point_y;
   logic signed [19:0] point_z;
   logic [11:0]        source_index;
   modport source (output valid, point_x, point_y, point_z, source_index, input ready);
   modport sink (input valid, point_x, point_y, point_z, source_index, output ready);
endinterface

// ===== src/lstp_cordic_cell.sv =====
// One CORDIC rotation cell of the angle chain, with its own valid/ready stage.
// Depends on lstp_pkg.
module lstp_cordic_cell
   import lstp_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   output logic          up_ready,
   input  lstp_cell_type up_data,
   output logic          dn_valid,
   input  logic          dn_ready,
   output lstp_cell_type dn_data
);
   logic          v_ff, v_in;
   lstp_cell_type d_ff, d_in;
   logic signed [17:0] dx, dy;

   assign up_ready = !v_ff || dn_ready;
   assign v_in = up_ready ? up_valid : v_ff;

   always_comb begin
      dx = up_data.y >>> STAGE;
      dy = up_data.x >>> STAGE;
      d_in = up_data;
      if (!up_data.z[31]) begin
         d_in.x = up_data.x - dx;
         d_in.y = up_data.y + dy;
         d_in.z = up_data.z - atan_turns(STAGE);
      end else begin
         d_in.x = up_data.x + dx;
         d_in.y = up_data.y - dy;
         d_in.z = up_data.z + atan_turns(STAGE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         d_ff <= d_in;
      end
   end

   assign dn_valid = v_ff;
   assign dn_data = d_ff;
endmodule

// ===== src/lstp_xform.sv =====
// Quadrant map, range scaling, rigid transform, footprint drop and saturation.
// Depends on lstp_pkg and lstp_rsp_if.
module lstp_xform
   import lstp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   output logic          up_ready,
   input  lstp_cell_type up_data,
   input  lstp_csr_type  csr,
   lstp_rsp_if.source    rsp_ch
);
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4;
   logic signed [17:0] cs, sn;
   logic signed [34:0] px_ff, py_ff;
   logic [11:0] idx1_ff, idx2_ff, idx3_ff;
   logic signed [50:0] pxx_ff, pxy_ff, pyx_ff, pyy_ff, pzx_ff, pzy_ff;
   logic signed [35:0] bx_ff, by_ff, bz_ff, bx_in, by_in, bz_in;
   logic signed [19:0] ox_ff, oy_ff, oz_ff;
   logic [11:0] oidx_ff;
   logic signed [35:0] hl, hw;
   logic in_box;

   assign adv4 = !v4_ff || rsp_ch.ready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign up_ready = adv1;

   always_comb begin
      case (up_data.quad)
         2'd0: begin cs = up_data.x;  sn = up_data.y;  end
         2'd1: begin cs = -up_data.y; sn = up_data.x;  end
         2'd2: begin cs = -up_data.x; sn = -up_data.y; end
         default: begin cs = up_data.y; sn = -up_data.x; end
      endcase
   end

   function automatic logic signed [35:0] row(input logic signed [50:0] a,
                                             input logic signed [50:0] b,
                                             input logic [31:0] t);
      logic signed [52:0] s;
      s = 53'(a) + 53'(b) + 53'sd134217728;
      return 36'(s >>> 28) + 36'($signed(t));
   endfunction

   always_comb begin
      bx_in = row(pxx_ff, pxy_ff, csr.offset_xy[63:32]);
      by_in = row(pyx_ff, pyy_ff, csr.offset_xy[31:0]);
      bz_in = row(pzx_ff, pzy_ff, csr.rotation_z_offset[31:0]);
      hl = 36'($signed({1'b0, csr.footprint_half[31:16]}));
      hw = 36'($signed({1'b0, csr.footprint_half[15:0]}));
      in_box = (bx_ff > -hl) && (bx_ff < hl) && (by_ff > -hw) && (by_ff < hw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= up_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff && !in_box;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         px_ff   <= $signed({1'b0, up_data.range_mm}) * cs;
         py_ff   <= $signed({1'b0, up_data.range_mm}) * sn;
         idx1_ff <= up_data.beam_index;
      end
      if (adv2) begin
         pxx_ff  <= $signed(csr.rotation_xy[63:48]) * px_ff;
         pxy_ff  <= $signed(csr.rotation_xy[47:32]) * py_ff;
         pyx_ff  <= $signed(csr.rotation_xy[31:16]) * px_ff;
         pyy_ff  <= $signed(csr.rotation_xy[15:0]) * py_ff;
         pzx_ff  <= $signed(csr.rotation_z_offset[63:48]) * px_ff;
         pzy_ff  <= $signed(csr.rotation_z_offset[47:32]) * py_ff;
         idx2_ff <= idx1_ff;
      end
      if (adv3) begin
         bx_ff   <= bx_in;
         by_ff   <= by_in;
         bz_ff   <= bz_in;
         idx3_ff <= idx2_ff;
      end
      if (adv4) begin
         ox_ff   <= sat20(bx_ff);
         oy_ff   <= sat20(by_ff);
         oz_ff   <= sat20(bz_ff);
         oidx_ff <= idx3_ff;
      end
   end

   assign rsp_ch.valid = v4_ff;
   assign rsp_ch.point_x = ox_ff;
   assign rsp_ch.point_y = oy_ff;
   assign rsp_ch.point_z = oz_ff;
   assign rsp_ch.source_index = oidx_ff;
endmodule

// ===== src/laser_scan_to_point_filter.sv =====
// Lidar range sample to body-frame point with range gate and footprint filter.
// Depends on lstp_pkg, lstp_if, lstp_cordic_cell and lstp_xform.
//
// One sample is taken every clock while the output is not stalled. A kept
// sample passes through the beam-angle register, one register per CORDIC
// cell in the chain, and the scaling, transform, sum and filter stages. Each
// stage holds its own word, so stalls on the output fill bubbles first.
// Configure only while the pipeline is empty.
module laser_scan_to_point_filter
   import lstp_pkg::*;
#(
   parameter int MAX_BEAMS = 4096,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   lstp_req_if.sink                 req_ch,
   lstp_rsp_if.source               rsp_ch,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);
   logic [15:0]  start_angle_ff, angle_step_ff, min_range_ff, max_range_ff;
   lstp_csr_type csr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff <= 16'd0;
         angle_step_ff  <= 16'd16;
         min_range_ff   <= 16'd0;
         max_range_ff   <= 16'hFFFF;
         csr_ff.rotation_xy       <= 64'h4000_0000_0000_4000;
         csr_ff.rotation_z_offset <= 64'd0;
         csr_ff.offset_xy         <= 64'd0;
         csr_ff.footprint_half    <= 32'h012C_0190;
      end else if (csr_we) begin
         case (csr_index)
            CSR_START_ANGLE:    start_angle_ff <= csr_data[15:0];
            CSR_ANGLE_STEP:     angle_step_ff <= csr_data[15:0];
            CSR_MIN_RANGE:      min_range_ff <= csr_data[15:0];
            CSR_MAX_RANGE:      max_range_ff <= csr_data[15:0];
            CSR_ROTATION_XY:    csr_ff.rotation_xy <= csr_data;
            CSR_ROTATION_Z_OFS: csr_ff.rotation_z_offset <= csr_data;
            CSR_OFFSET_XY:      csr_ff.offset_xy <= csr_data;
            CSR_FOOTPRINT_HALF: csr_ff.footprint_half <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   logic          c_valid [0:CORDIC_STAGES];
   logic          c_ready [0:CORDIC_STAGES];
   lstp_cell_type c_data  [0:CORDIC_STAGES];

   logic          front_v_ff, front_v_in, accept, keep;
   lstp_cell_type front_d_ff, front_d_in;
   logic [27:0]   step_prod;
   logic [15:0]   angle;

   assign req_ch.ready = !front_v_ff || c_ready[0];
   assign accept = req_ch.valid && req_ch.ready;
   assign keep = req_ch.range_finite && (req_ch.range_mm > min_range_ff)
              && (req_ch.range_mm < max_range_ff)
              && (32'(req_ch.beam_index) < 32'(MAX_BEAMS));
   assign front_v_in = req_ch.ready ? (accept && keep) : front_v_ff;

   always_comb begin
      step_prod = req_ch.beam_index * angle_step_ff;
      angle = start_angle_ff + step_prod[15:0];
      front_d_in.x = CordicGainQ14;
      front_d_in.y = 18'sd0;
      front_d_in.z = $signed({2'b00, angle[13:0], 16'h0000});
      front_d_in.quad = angle[15:14];
      front_d_in.range_mm = req_ch.range_mm;
      front_d_in.beam_index = req_ch.beam_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
      end else begin
         front_v_ff <= front_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         front_d_ff <= front_d_in;
      end
   end

   assign c_valid[0] = front_v_ff;
   assign c_data[0] = front_d_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      lstp_cordic_cell #(.STAGE(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (c_valid[i]),
         .up_ready (c_ready[i]),
         .up_data  (c_data[i]),
         .dn_valid (c_valid[i+1]),
         .dn_ready (c_ready[i+1]),
         .dn_data  (c_data[i+1])
      );
   end

   lstp_xform u_xform (
      .clock    (clock),
      .reset    (reset),
      .up_valid (c_valid[CORDIC_STAGES]),
      .up_ready (c_ready[CORDIC_STAGES]),
      .up_data  (c_data[CORDIC_STAGES]),
      .csr      (csr_ff),
      .rsp_ch   (rsp_ch)
   );

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> front_v_ff) else $error("input stalled with empty front stage");

   a_drop_not_finite: assert property (@(posedge clock) disable iff (reset)
      accept && !req_ch.range_finite |=> !front_v_ff)
      else $error("non-finite sample entered the pipeline");

   a_index_in_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (32'(rsp_ch.source_index) < 32'(MAX_BEAMS)))
      else $error("point from beam beyond scan");
endmodule
